@@ design/flash_record_validator_defines.svh @@
`ifndef FLASH_RECORD_VALIDATOR_DEFINES_SVH
`define FLASH_RECORD_VALIDATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FRV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FRV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/frv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package frv_pkg;

    localparam logic [31:0] CRC_POLY       = 32'hedb88320;
    localparam logic [31:0] CRC_INIT       = 32'hffffffff;
    localparam logic [15:0] FORMAT_VERSION = 16'd1;

    // last byte of each little-endian header field, plus the header CRC start and the end of the fields
    localparam int unsigned POS_FORMAT_END = 5;
    localparam int unsigned POS_SCHEMA_END = 7;
    localparam int unsigned POS_GEN_END    = 11;
    localparam int unsigned POS_LEN_END    = 15;
    localparam int unsigned POS_PCRC_END   = 19;
    localparam int unsigned HCRC_POS       = 20;
    localparam int unsigned POS_HCRC_END   = 23;
    localparam int unsigned FIELDS_END     = 24;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_MAGIC       = 3'd1,
        ST_FORMAT      = 3'd2,
        ST_SCHEMA      = 3'd3,
        ST_LENGTH      = 3'd4,
        ST_HEADER_CRC  = 3'd5,
        ST_PADDING     = 3'd6,
        ST_PAYLOAD_CRC = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        CFG_PAYLOAD_LENGTH = 2'd0,
        CFG_SCHEMA_VERSION = 2'd1,
        CFG_LEGACY_SCHEMA  = 2'd2
    } t_cfg_idx;

    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h53;
            2'd1:    m = 8'h50;
            2'd2:    m = 8'h50;
            default: m = 8'h46;
        endcase
        return m;
    endfunction

    // reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = (x >> 1) ^ (x[0] ? CRC_POLY : 32'd0);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

@@ design/flash_record_validator.sv @@
// Record header/payload validator, one record byte per beat.
// Input channel: i_in_valid / o_in_stall carrying i_data_byte and i_record_start.
// A beat with i_record_start high is byte 0 of a record and drops any partial one.
// The record is HEADER_BYTES header bytes then payload_length payload bytes.
// Output channel: o_out_valid / i_out_stall, one beat per record on its last byte,
// carrying validity, the first failed check, generation and stored payload CRC.
// A result passes through the input register, then the result register.
// Throughput: one byte per cycle unless the receiver stalls; CRC over a byte is a combinational XOR network.
// Bytes past the end of a record are dropped until the next record start.
// Receiver stall: the result register holds; the input register then fills and
// o_in_stall rises in the same cycle, so no beat is lost.
// Configuration: i_cfg_we writes register i_cfg_index (0 payload length,
// 1 schema version, 2 legacy schema version); write only while idle.
// Reset (i_rst_n low, synchronous) clears the registers, record state and both
// pipeline valids.
`timescale 1ns / 1ps
`default_nettype none
`include "flash_record_validator_defines.svh"

module flash_record_validator
    import frv_pkg::*;
#(
    parameter int unsigned HEADER_BYTES = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_record_start,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_record_valid,
    output logic             o_header_valid,
    output logic [2:0]       o_status_code,
    output logic             o_is_legacy_schema,
    output logic [31:0]      o_generation,
    output logic [31:0]      o_payload_checksum
);

    localparam int unsigned POS_W = $clog2(HEADER_BYTES + 65536);

    // configuration
    logic [15:0] r_payload_length, r_schema_version, r_legacy_schema;

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_start;

    // record state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_fs, n_fs;
    logic [31:0] r_hcrc, n_hcrc;
    logic [31:0] r_gen, n_gen;
    logic [31:0] r_pcrc, n_pcrc;
    t_status     r_err, n_err;
    logic        r_leg, n_leg;

    // result register
    logic        r_out_valid, n_out_valid;
    logic        r_rec_ok, n_rec_ok;
    logic        r_hdr_ok, n_hdr_ok;
    t_status     r_status, n_status;
    logic        r_out_leg, n_out_leg;
    logic [31:0] r_out_gen, n_out_gen;
    logic [31:0] r_out_pcrc, n_out_pcrc;

    // working values
    logic             out_free, proc, live, emit, hv;
    logic [POS_W-1:0] total, c_pos, pos_inc;
    logic [31:0]      c_crc, c_fs, c_hcrc, c_gen, c_pcrc, fs_new;
    t_status          c_err;
    logic             c_leg;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_length <= '0;
            r_schema_version <= '0;
            r_legacy_schema  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PAYLOAD_LENGTH: r_payload_length <= i_cfg_wdata;
                CFG_SCHEMA_VERSION: r_schema_version <= i_cfg_wdata;
                CFG_LEGACY_SCHEMA:  r_legacy_schema  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && !o_in_stall) begin
            r_byte  <= i_data_byte;
            r_start <= i_record_start;
        end
    end

    always_comb begin
        total = POS_W'(HEADER_BYTES) + POS_W'(r_payload_length);

        c_pos  = r_start ? '0 : r_pos;
        c_crc  = r_start ? CRC_INIT : r_crc;
        c_fs   = r_start ? '0 : r_fs;
        c_hcrc = r_start ? '0 : r_hcrc;
        c_gen  = r_start ? '0 : r_gen;
        c_pcrc = r_start ? '0 : r_pcrc;
        c_err  = r_start ? ST_OK : r_err;
        c_leg  = r_start ? 1'b0 : r_leg;

        live    = c_pos < total;
        fs_new  = {r_byte, c_fs[31:8]};
        pos_inc = c_pos + POS_W'(1);

        n_pos  = c_pos;
        n_crc  = c_crc;
        n_fs   = c_fs;
        n_hcrc = c_hcrc;
        n_gen  = c_gen;
        n_pcrc = c_pcrc;
        n_err  = c_err;
        n_leg  = c_leg;

        if (live) begin
            n_fs  = fs_new;
            n_pos = pos_inc;
            if (c_pos < POS_W'(HCRC_POS) || c_pos >= POS_W'(HEADER_BYTES)) begin
                n_crc = crc_byte(c_crc, r_byte);
            end
            if (c_pos < POS_W'(4)) begin
                if (r_byte != magic_byte(c_pos[1:0]) && n_err == ST_OK) n_err = ST_MAGIC;
            end else if (c_pos == POS_W'(POS_FORMAT_END)) begin
                if (fs_new[31:16] != FORMAT_VERSION && n_err == ST_OK) n_err = ST_FORMAT;
            end else if (c_pos == POS_W'(POS_SCHEMA_END)) begin
                if (fs_new[31:16] != r_schema_version && fs_new[31:16] != r_legacy_schema) begin
                    if (n_err == ST_OK) n_err = ST_SCHEMA;
                end else begin
                    n_leg = fs_new[31:16] != r_schema_version;
                end
            end else if (c_pos == POS_W'(POS_GEN_END)) begin
                n_gen = fs_new;
            end else if (c_pos == POS_W'(POS_LEN_END)) begin
                if (fs_new != {16'd0, r_payload_length} && n_err == ST_OK) n_err = ST_LENGTH;
            end else if (c_pos == POS_W'(POS_PCRC_END)) begin
                n_pcrc = fs_new;
                n_hcrc = ~n_crc;
                n_crc  = CRC_INIT;
            end else if (c_pos == POS_W'(POS_HCRC_END)) begin
                if (fs_new != c_hcrc && n_err == ST_OK) n_err = ST_HEADER_CRC;
            end else if (c_pos >= POS_W'(FIELDS_END) && c_pos < POS_W'(HEADER_BYTES)) begin
                if (r_byte != 8'd0 && n_err == ST_OK) n_err = ST_PADDING;
            end
        end

        emit = live && (pos_inc == total);
        hv   = n_err == ST_OK;
        if (emit && hv && (~n_crc) != n_pcrc) begin
            n_err = ST_PAYLOAD_CRC;
        end

        n_out_valid = r_out_valid;
        n_rec_ok    = r_rec_ok;
        n_hdr_ok    = r_hdr_ok;
        n_status    = r_status;
        n_out_leg   = r_out_leg;
        n_out_gen   = r_out_gen;
        n_out_pcrc  = r_out_pcrc;
        if (out_free) begin
            n_out_valid = proc && emit;
            n_rec_ok    = n_err == ST_OK;
            n_hdr_ok    = hv;
            n_status    = n_err;
            n_out_leg   = hv && n_leg;
            n_out_gen   = hv ? n_gen : 32'd0;
            n_out_pcrc  = hv ? n_pcrc : 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_fs        <= '0;
            r_hcrc      <= '0;
            r_gen       <= '0;
            r_pcrc      <= '0;
            r_err       <= ST_OK;
            r_leg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (proc) begin
                r_pos  <= n_pos;
                r_crc  <= n_crc;
                r_fs   <= n_fs;
                r_hcrc <= n_hcrc;
                r_gen  <= n_gen;
                r_pcrc <= n_pcrc;
                r_err  <= n_err;
                r_leg  <= n_leg;
            end
            r_out_valid <= n_out_valid;
        end
        r_rec_ok   <= n_rec_ok;
        r_hdr_ok   <= n_hdr_ok;
        r_status   <= n_status;
        r_out_leg  <= n_out_leg;
        r_out_gen  <= n_out_gen;
        r_out_pcrc <= n_out_pcrc;
    end

    assign o_out_valid        = r_out_valid;
    assign o_record_valid     = r_rec_ok;
    assign o_header_valid     = r_hdr_ok;
    assign o_status_code      = r_status;
    assign o_is_legacy_schema = r_out_leg;
    assign o_generation       = r_out_gen;
    assign o_payload_checksum = r_out_pcrc;

    `FRV_ASSERT_NOW(a_rec_ok_implies_hdr, i_clk, i_rst_n,
        r_out_valid && r_rec_ok, r_hdr_ok && r_status == ST_OK,
        "record valid without clean header")
    `FRV_ASSERT_NOW(a_bad_hdr_zero_fields, i_clk, i_rst_n,
        r_out_valid && !r_hdr_ok, r_out_gen == 32'd0 && r_out_pcrc == 32'd0 && !r_out_leg,
        "header fields leaked on bad header")
    `FRV_ASSERT_NOW(a_hdr_ok_status, i_clk, i_rst_n,
        r_out_valid && r_hdr_ok, r_status == ST_OK || r_status == ST_PAYLOAD_CRC,
        "header error code with header valid")
    `FRV_ASSERT_NEXT(a_stall_holds_input, i_clk, i_rst_n,
        o_in_stall, r_in_valid && $stable(r_byte) && $stable(r_start),
        "stalled input register changed")

endmodule

`default_nettype wire
